@@ hw/rtl/u8dec_pkg.sv @@
// Shared types and constants of the streaming UTF-8 validating decoder.
package u8dec_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_CHAR = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  // Range rule applied to the next continuation byte
  typedef enum logic [2:0] {
    RULE_ANY = 3'd0,  // 80..BF
    RULE_E0  = 3'd1,  // A0..BF
    RULE_ED  = 3'd2,  // 80..9F
    RULE_F0  = 3'd3,  // 90..BF
    RULE_F4  = 3'd4   // 80..8F
  } rule_e;

  // Lead byte boundaries
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_SUR = 8'hED;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;

  // Continuation byte boundaries
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] CONT_E0_MIN = 8'hA0;
  localparam logic [7:0] CONT_ED_MAX = 8'h9F;
  localparam logic [7:0] CONT_F0_MIN = 8'h90;
  localparam logic [7:0] CONT_F4_MAX = 8'h8F;

  // Largest scalar value
  localparam logic [20:0] CP_LIMIT = 21'h10FFFF;

  // Per-string decode state, apart from the offset counters
  typedef struct packed {
    logic [1:0]  pending;
    logic [2:0]  seq_len;
    logic [20:0] partial;
    rule_e       rule;
    logic        failed;
  } dec_state_t;

  // Result of one byte, apart from the offset
  typedef struct packed {
    status_e     status;
    logic [20:0] codepoint;
    logic [2:0]  char_width;
    logic [31:0] char_total;
    logic        string_end;
  } dec_res_t;

endpackage

@@ hw/rtl/utf8_stream_validator_decoder_unit.sv @@
// Streaming strict UTF-8 validator and decoder, one byte per transfer.
// Takes one byte per clock and gives one result per byte, registered for the cycle after the
// byte's transfer; with the output side always ready it sustains one byte per cycle. The
// single result register refills in the same cycle that it is drained, so the input
// stalls only while a result waits unclaimed. Each result carries a status (pending,
// character completed, or error), the code point and byte width of a completed
// character, the start offset of that character or of the failing sequence, the running
// character count and a flag for the final byte of the string. After the first error
// the rest of the string gives pending results; all state clears after the final byte.
module utf8_stream_validator_decoder_unit #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           byte_in_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u8dec_pkg::status_e   status_o,
  output logic [20:0]          codepoint_o,
  output logic [2:0]           char_width_o,
  output logic [31:0]          char_offset_o,
  output logic [31:0]          char_total_o,
  output logic                 string_end_o
);
  import u8dec_pkg::*;

  dec_state_t             state_q, state_d;
  logic [OFFSET_BITS-1:0] byte_pos_q, byte_pos_d;
  logic [OFFSET_BITS-1:0] seq_start_q, seq_start_d;
  logic [31:0]            chars_q, chars_d;
  dec_res_t               res_q, res_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic                   out_valid_q;
  logic                   in_xfer;

  // Accept whenever the result register is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  u8dec_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .byte_in_i  (byte_in_i),
    .last_i     (last_i),
    .state_i    (state_q),
    .byte_pos_i (byte_pos_q),
    .seq_start_i(seq_start_q),
    .chars_i    (chars_q),
    .state_o    (state_d),
    .byte_pos_o (byte_pos_d),
    .seq_start_o(seq_start_d),
    .chars_o    (chars_d),
    .res_o      (res_d),
    .offset_o   (offset_d)
  );

  // Decode state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      byte_pos_q  <= '0;
      seq_start_q <= '0;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q     <= state_d;
        byte_pos_q  <= byte_pos_d;
        seq_start_q <= seq_start_d;
        chars_q     <= chars_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q    <= res_d;
      offset_q <= offset_d;
    end
  end

  // Low 32 bits of the offset, zero-extended for narrow counters
  generate
    if (OFFSET_BITS >= 32) begin : g_off_wide
      assign char_offset_o = offset_q[31:0];
    end else begin : g_off_narrow
      assign char_offset_o = {{(32-OFFSET_BITS){1'b0}}, offset_q};
    end
  endgenerate

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign codepoint_o  = res_q.codepoint;
  assign char_width_o = res_q.char_width;
  assign char_total_o = res_q.char_total;
  assign string_end_o = res_q.string_end;

endmodule

@@ hw/rtl/u8dec_step.sv @@
// Next-state and result logic for one byte of the UTF-8 decoder.
module u8dec_step #(
  parameter int OFFSET_BITS = 32
) (
  input  logic [7:0]             byte_in_i,
  input  logic                   last_i,
  input  u8dec_pkg::dec_state_t  state_i,
  input  logic [OFFSET_BITS-1:0] byte_pos_i,
  input  logic [OFFSET_BITS-1:0] seq_start_i,
  input  logic [31:0]            chars_i,
  output u8dec_pkg::dec_state_t  state_o,
  output logic [OFFSET_BITS-1:0] byte_pos_o,
  output logic [OFFSET_BITS-1:0] seq_start_o,
  output logic [31:0]            chars_o,
  output u8dec_pkg::dec_res_t    res_o,
  output logic [OFFSET_BITS-1:0] offset_o
);
  import u8dec_pkg::*;

  logic cont_ok;
  logic err;
  logic [1:0] pend_dec;

  // Range check on a continuation byte under the current rule
  always_comb begin
    case (state_i.rule)
      RULE_E0: cont_ok = byte_in_i inside {[CONT_E0_MIN:CONT_MAX]};
      RULE_ED: cont_ok = byte_in_i inside {[CONT_MIN:CONT_ED_MAX]};
      RULE_F0: cont_ok = byte_in_i inside {[CONT_F0_MIN:CONT_MAX]};
      RULE_F4: cont_ok = byte_in_i inside {[CONT_MIN:CONT_F4_MAX]};
      default: cont_ok = byte_in_i inside {[CONT_MIN:CONT_MAX]};
    endcase
  end

  assign pend_dec = state_i.pending - 2'd1;

  // Decode step
  always_comb begin
    state_o     = state_i;
    seq_start_o = seq_start_i;
    chars_o     = chars_i;
    err         = 1'b0;
    res_o.status     = ST_NONE;
    res_o.codepoint  = '0;
    res_o.char_width = '0;
    offset_o         = '0;

    if (state_i.failed) begin
      // bytes ignored until the end of the string
    end else if (state_i.pending == 2'd0) begin
      seq_start_o = byte_pos_i;
      state_o.rule = RULE_ANY;
      if (!byte_in_i[7]) begin
        res_o.status     = ST_CHAR;
        res_o.codepoint  = {13'd0, byte_in_i};
        res_o.char_width = 3'd1;
        offset_o         = byte_pos_i;
      end else if (byte_in_i inside {[LEAD2_MIN:LEAD2_MAX]}) begin
        state_o.seq_len = 3'd2;
        state_o.pending = 2'd1;
        state_o.partial = {16'd0, byte_in_i[4:0]};
        err = last_i;
      end else if (byte_in_i inside {[LEAD3_MIN:LEAD3_MAX]}) begin
        state_o.seq_len = 3'd3;
        state_o.pending = 2'd2;
        state_o.partial = {17'd0, byte_in_i[3:0]};
        if (byte_in_i == LEAD3_MIN) begin
          state_o.rule = RULE_E0;
        end else if (byte_in_i == LEAD3_SUR) begin
          state_o.rule = RULE_ED;
        end
        err = last_i;
      end else if (byte_in_i inside {[LEAD4_MIN:LEAD4_MAX]}) begin
        state_o.seq_len = 3'd4;
        state_o.pending = 2'd3;
        state_o.partial = {18'd0, byte_in_i[2:0]};
        if (byte_in_i == LEAD4_MIN) begin
          state_o.rule = RULE_F0;
        end else if (byte_in_i == LEAD4_MAX) begin
          state_o.rule = RULE_F4;
        end
        err = last_i;
      end else begin
        err = 1'b1;
      end
    end else if (!cont_ok) begin
      err = 1'b1;
    end else begin
      state_o.partial = {state_i.partial[14:0], byte_in_i[5:0]};
      state_o.rule    = RULE_ANY;
      state_o.pending = pend_dec;
      if (pend_dec == 2'd0) begin
        res_o.status     = ST_CHAR;
        res_o.codepoint  = state_o.partial;
        res_o.char_width = state_i.seq_len;
        offset_o         = seq_start_i;
        state_o.seq_len  = 3'd0;
        state_o.partial  = '0;
      end else begin
        err = last_i;
      end
    end

    // Error reporting, or character count update
    if (err) begin
      res_o.status     = ST_ERR;
      res_o.codepoint  = '0;
      res_o.char_width = '0;
      offset_o         = seq_start_o;
      state_o.failed   = 1'b1;
      state_o.pending  = '0;
      state_o.seq_len  = '0;
      state_o.partial  = '0;
      state_o.rule     = RULE_ANY;
    end else if (res_o.status == ST_CHAR && chars_i != '1) begin
      chars_o = chars_i + 32'd1;
    end

    res_o.char_total = chars_o;
    res_o.string_end = last_i;

    // Saturating byte offset
    byte_pos_o = (byte_pos_i != '1) ? byte_pos_i + 1'b1 : byte_pos_i;

    // Final byte returns all state to reset
    if (last_i) begin
      state_o     = '0;
      seq_start_o = '0;
      chars_o     = '0;
      byte_pos_o  = '0;
    end
  end

endmodule

@@ hw/rtl/u8dec_checker.sv @@
// Port-level checker for the UTF-8 decoder, bound to the top level.
module u8dec_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input u8dec_pkg::status_e  status_o,
  input logic [20:0]         codepoint_o,
  input logic [2:0]          char_width_o,
  input logic [31:0]         char_offset_o,
  input logic [31:0]         char_total_o,
  input logic                string_end_o
);
  import u8dec_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(codepoint_o) && $stable(char_width_o) && $stable(char_offset_o)
      && $stable(char_total_o) && $stable(string_end_o))
    else $error("stalled result changed");

  // Input stalls only behind an unclaimed result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without back-pressure");

  // Non-character results carry no code point or width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_CHAR |-> codepoint_o == 21'd0 && char_width_o == 3'd0)
    else $error("stray code point on non-character result");

  // Completed characters are legal scalar values of sensible width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CHAR |->
      (char_width_o == 3'd1 || char_width_o == 3'd2 || char_width_o == 3'd3
        || char_width_o == 3'd4)
      && codepoint_o <= CP_LIMIT && char_total_o != 32'd0)
    else $error("bad character result");

  // Three-byte characters are neither overlong nor surrogates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CHAR && char_width_o == 3'd3 |->
      codepoint_o >= 21'h000800 && (codepoint_o < 21'h00D800 || codepoint_o > 21'h00DFFF))
    else $error("overlong or surrogate three-byte character");

endmodule

bind utf8_stream_validator_decoder_unit u8dec_checker u_checker (.*);

@@ sim/utf8_stream_validator_decoder_unit_tb.sv @@
// Self-checking testbench for the streaming UTF-8 validating decoder.
`timescale 1ns / 1ps

module utf8_stream_validator_decoder_unit_tb;
  import u8dec_pkg::*;

  localparam int OFFSET_BITS = 32;
  localparam logic [63:0] POS_MAX = (64'd1 << OFFSET_BITS) - 64'd1;

  // One decoded result as the block should present it
  typedef struct {
    status_e     status;
    logic [20:0] cp;
    logic [2:0]  width;
    logic [31:0] offset;
    logic [31:0] total;
    logic        str_end;
  } utf8_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_in_i = 8'h00;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  status_e     status_o;
  logic [20:0] codepoint_o;
  logic [2:0]  char_width_o;
  logic [31:0] char_offset_o;
  logic [31:0] char_total_o;
  logic        string_end_o;

  utf8_stream_validator_decoder_unit #(
    .OFFSET_BITS(OFFSET_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .codepoint_o  (codepoint_o),
    .char_width_o (char_width_o),
    .char_offset_o(char_offset_o),
    .char_total_o (char_total_o),
    .string_end_o (string_end_o)
  );

  // Decoder state mirrored by the predictor
  logic [1:0]  dec_pending;
  logic [2:0]  dec_len;
  logic [20:0] dec_partial;
  rule_e       dec_rule;
  logic [63:0] dec_pos;
  logic [63:0] dec_start;
  logic [31:0] dec_count;
  logic        dec_failed;

  utf8_result_t expected_results[$];
  logic [7:0]   pending_string[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatch_count = 0;
  int live_bytes = 0;
  int strings_sent = 0;
  int chars_seen = 0;
  int errors_seen = 0;
  int results_seen = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_decoder_state();
    dec_pending = '0;
    dec_len     = '0;
    dec_partial = '0;
    dec_rule    = RULE_ANY;
    dec_pos     = '0;
    dec_start   = '0;
    dec_count   = '0;
    dec_failed  = 1'b0;
  endfunction

  // Allowed range of the next continuation byte
  function automatic bit continuation_ok(logic [7:0] b, rule_e rl);
    case (rl)
      RULE_E0: return b >= CONT_E0_MIN && b <= CONT_MAX;
      RULE_ED: return b >= CONT_MIN && b <= CONT_ED_MAX;
      RULE_F0: return b >= CONT_F0_MIN && b <= CONT_MAX;
      RULE_F4: return b >= CONT_MIN && b <= CONT_F4_MAX;
      default: return b >= CONT_MIN && b <= CONT_MAX;
    endcase
  endfunction

  // Advance the mirrored decoder by one byte and give the result it should produce
  function automatic utf8_result_t decode_next_byte(logic [7:0] b, logic fin);
    utf8_result_t r;
    logic [2:0]   len;
    logic [20:0]  val;
    rule_e        rl;
    logic         err;
    r.status = ST_NONE;
    r.cp     = '0;
    r.width  = '0;
    r.offset = '0;
    len = '0;
    val = '0;
    rl  = RULE_ANY;
    err = 1'b0;
    if (dec_failed) begin
      // rest of the string is skipped
    end else if (dec_pending == 2'd0) begin
      dec_start = dec_pos;
      if (b < CONT_MIN) begin
        r.status = ST_CHAR;
        r.cp     = {13'd0, b};
        r.width  = 3'd1;
        r.offset = dec_pos[31:0];
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        len = 3'd2;
        val = {16'd0, b[4:0]};
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        len = 3'd3;
        val = {17'd0, b[3:0]};
        if (b == LEAD3_MIN) rl = RULE_E0;
        else if (b == LEAD3_SUR) rl = RULE_ED;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        len = 3'd4;
        val = {18'd0, b[2:0]};
        if (b == LEAD4_MIN) rl = RULE_F0;
        else if (b == LEAD4_MAX) rl = RULE_F4;
      end else begin
        err = 1'b1;
      end
      if (len != 3'd0) begin
        dec_len     = len;
        dec_pending = 2'(len - 3'd1);
        dec_partial = val;
        dec_rule    = rl;
        if (fin) err = 1'b1;
      end
    end else if (!continuation_ok(b, dec_rule)) begin
      err = 1'b1;
    end else begin
      dec_partial = {dec_partial[14:0], b[5:0]};
      dec_rule    = RULE_ANY;
      dec_pending = dec_pending - 2'd1;
      if (dec_pending == 2'd0) begin
        r.status    = ST_CHAR;
        r.cp        = dec_partial;
        r.width     = dec_len;
        r.offset    = dec_start[31:0];
        dec_len     = '0;
        dec_partial = '0;
      end else if (fin) begin
        err = 1'b1;
      end
    end

    if (err) begin
      r.status    = ST_ERR;
      r.cp        = '0;
      r.width     = '0;
      r.offset    = dec_start[31:0];
      dec_failed  = 1'b1;
      dec_pending = '0;
      dec_len     = '0;
      dec_partial = '0;
      dec_rule    = RULE_ANY;
    end else if (r.status == ST_CHAR && dec_count != '1) begin
      dec_count = dec_count + 32'd1;
    end
    r.total   = dec_count;
    r.str_end = fin;

    if (dec_pos < POS_MAX) dec_pos = dec_pos + 64'd1;
    if (fin) clear_decoder_state();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", fname, got, want));
  endtask

  // Output side: random back-pressure, and every transfer checked against the oldest
  // expectation
  always @(posedge clk_i) begin : result_check
    utf8_result_t want;
    out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (status_o == ST_CHAR) chars_seen++;
      if (status_o == ST_ERR) errors_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_results.pop_front();
        compare_field("status", status_o, want.status);
        compare_field("codepoint", codepoint_o, want.cp);
        compare_field("char_width", char_width_o, want.width);
        compare_field("char_offset", char_offset_o, want.offset);
        compare_field("char_total", char_total_o, want.total);
        compare_field("string_end", string_end_o, want.str_end);
      end
    end
  end

  // Offer one byte, with random gaps first, and predict once it is transferred
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    last_i     <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!dec_failed) live_bytes++;
    expected_results.push_back(decode_next_byte(b, fin));
  endtask

  task automatic send_string();
    for (int i = 0; i < pending_string.size(); i++)
      send_byte(pending_string[i], i == pending_string.size() - 1);
    strings_sent++;
  endtask

  // Hold the input off until every outstanding result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Append one well-formed character of the given width, sometimes at a range edge
  task automatic append_char(input int w);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    int          pick;
    case (w)
      1:       begin lo = 21'h0;     hi = 21'h7F;   end
      2:       begin lo = 21'h80;    hi = 21'h7FF;  end
      3:       begin lo = 21'h800;   hi = 21'hFFFF; end
      default: begin lo = 21'h10000; hi = CP_LIMIT; end
    endcase
    cp   = 21'($urandom_range(hi, lo));
    pick = $urandom_range(7);
    if (pick == 0) cp = lo;
    if (pick == 1) cp = hi;
    // steer surrogates out to C800..CFFF
    if (w == 3 && cp[15:11] == 5'b11011) cp[12] = 1'b0;
    case (w)
      1: pending_string.push_back(cp[7:0]);
      2: begin
        pending_string.push_back({3'b110, cp[10:6]});
        pending_string.push_back({2'b10, cp[5:0]});
      end
      3: begin
        pending_string.push_back({4'b1110, cp[15:12]});
        pending_string.push_back({2'b10, cp[11:6]});
        pending_string.push_back({2'b10, cp[5:0]});
      end
      default: begin
        pending_string.push_back({5'b11110, cp[20:18]});
        pending_string.push_back({2'b10, cp[17:12]});
        pending_string.push_back({2'b10, cp[11:6]});
        pending_string.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Mostly well-formed strings; some with one corrupted byte, some cut short, some noise
  task automatic build_random_string();
    int kind;
    int n;
    int w;
    int cut;
    pending_string.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      n = $urandom_range(6, 1);
      repeat (n) pending_string.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(8, 1);
      repeat (n) append_char($urandom_range(4, 1));
      if (kind < 24) begin
        pending_string[$urandom_range(pending_string.size() - 1)] = 8'($urandom_range(255));
      end else if (kind < 34) begin
        w = $urandom_range(4, 2);
        append_char(w);
        cut = $urandom_range(w - 1, 1);
        repeat (cut) void'(pending_string.pop_back());
      end
    end
  endtask

  // Well-formed characters at range edges of every width and of the E0, ED and F4 second-byte rules
  task automatic test_valid_chars();
    pending_string = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                       8'hED, 8'h9F, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
  endtask

  // Good 4-byte character, then a bad second byte after E0, then skipped bytes
  task automatic test_sequence_errors();
    pending_string = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hE0, 8'h9F, 8'hFF, 8'h7F};
    send_string();
  endtask

  // Overlong lead byte as a whole string
  task automatic test_invalid_lead();
    pending_string = '{8'hC1};
    send_string();
  endtask

  // Final byte arrives with a 3-byte sequence still open
  task automatic test_truncated();
    pending_string = '{8'hE2, 8'h82};
    send_string();
  endtask

  task automatic test_random_strings(input int src_pct, input int snk_pct, input int quota);
    int start;
    int n;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = live_bytes;
    n = 0;
    while (live_bytes - start < quota) begin
      build_random_string();
      send_string();
      n++;
      if (n % 25 == 0) wait_for_results();
    end
  endtask

  // Test sequence
  initial begin
    clear_decoder_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 8;
    snk_idle_pct = 56;
    test_valid_chars();
    test_sequence_errors();
    test_invalid_lead();
    test_truncated();
    wait_for_results();

    test_random_strings(8, 56, 235);
    test_random_strings(56, 8, 235);
    test_random_strings(0, 0, 235);

    wait_for_results();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results over %0d strings: %0d characters, %0d errors.",
             results_seen, strings_sent, chars_seen, errors_seen);
    $display("Lead classes, range-limited second bytes, truncation and error skipping, "
             , "under three back-pressure mixes.");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/u8dec_pkg.sv
hw/rtl/u8dec_step.sv
hw/rtl/utf8_stream_validator_decoder_unit.sv
hw/rtl/u8dec_checker.sv
sim/utf8_stream_validator_decoder_unit_tb.sv
